// ===== sv/ppu_bmm_pkg.sv =====
// shared constants, types and the decoded address struct for the picture bus memory map
`timescale 1ns / 1ps
package ppu_bmm_pkg;

  localparam int unsigned PatternBytes   = 8192;
  localparam int unsigned NametableBytes = 2048;
  localparam int unsigned PaletteBytes   = 32;

  localparam int unsigned PatAw = $clog2(PatternBytes);
  localparam int unsigned NtAw  = $clog2(NametableBytes);
  localparam int unsigned PalAw = $clog2(PaletteBytes);

  // clearing pass covers the larger store, the smaller one is swept repeatedly
  localparam int unsigned ClrLen = (PatternBytes > NametableBytes) ?
                                   PatternBytes : NametableBytes;
  localparam int unsigned ClrAw  = $clog2(ClrLen);

  typedef enum logic [1:0] {
    CmdRead  = 2'd0,
    CmdWrite = 2'd1,
    CmdLoad  = 2'd2,
    CmdNone  = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    MirSingleLo = 2'd0,
    MirSingleHi = 2'd1,
    MirVert     = 2'd2,
    MirHoriz    = 2'd3
  } mirror_e;

  // configuration register indexes
  localparam logic CfgMirrorMode  = 1'b0;
  localparam logic CfgPatternIsRam = 1'b1;

  typedef enum logic [1:0] {
    RegPattern   = 2'd0,
    RegNametable = 2'd1,
    RegPalette   = 2'd2,
    RegZero      = 2'd3
  } region_e;

  typedef struct packed {
    region_e            region;
    logic [PatAw-1:0]   pat_idx;
    logic [NtAw-1:0]    nt_idx;
    logic [PalAw-1:0]   pal_idx;
  } dec_t;

endpackage

// ===== sv/ppu_bmm_addr_dec.sv =====
// picture bus address folding, region select and mirroring
`timescale 1ns / 1ps
module ppu_bmm_addr_dec (
  input  logic [15:0]          bus_address_i,
  input  logic [1:0]           mirror_mode_i,
  output ppu_bmm_pkg::dec_t    dec_o
);
  import ppu_bmm_pkg::*;

  logic [15:0] addr;
  logic        table_sel;
  logic [10:0] nt_full;
  logic [4:0]  pal_full;

  always_comb begin
    // 0x4000 and above fold onto 0x3xxx
    if (bus_address_i[15:14] != 2'b00) begin
      addr = {4'h3, bus_address_i[11:0]};
    end else begin
      addr = bus_address_i;
    end

    unique case (mirror_e'(mirror_mode_i))
      MirSingleLo: table_sel = 1'b0;
      MirSingleHi: table_sel = 1'b1;
      MirVert:     table_sel = addr[10];
      MirHoriz:    table_sel = addr[11];
      default:     table_sel = addr[11];
    endcase

    nt_full  = {table_sel, addr[9:0]};
    // entries 0x10, 0x14, 0x18, 0x1c alias entries 0x00, 0x04, 0x08, 0x0c
    pal_full = (addr[1:0] != 2'b00) ? addr[4:0] : {1'b0, addr[3:0]};

    if (addr[15:13] == 3'b000) begin
      dec_o.region = RegPattern;
    end else if (addr[13:8] == 6'h3F) begin
      dec_o.region = RegPalette;
    end else begin
      dec_o.region = RegNametable;
    end

    dec_o.pat_idx = PatAw'({3'b000, addr[12:0]});
    dec_o.nt_idx  = NtAw'(nt_full);
    dec_o.pal_idx = PalAw'(pal_full);
  end

endmodule

// ===== sv/ppu_bus_memory_map_unit.sv =====
// top level: picture bus memory map with pattern, nametable and palette stores
// latency: result is valid the cycle after the request is accepted
// throughput: one request per cycle unless the output stalls, set by the single-port pattern and nametable rams
// reset: config registers reset at once; a clearing pass then zeroes the pattern
// and nametable rams, in_ready_o stays low during it; palette resets at once
`timescale 1ns / 1ps
module ppu_bus_memory_map_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic        cfg_idx_i,
  input  logic [1:0]  cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  cmd_i,
  input  logic [15:0] bus_address_i,
  input  logic [7:0]  write_data_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [7:0]  read_data_o
);
  import ppu_bmm_pkg::*;

  logic [1:0]       mirror_mode_q;
  logic             pattern_is_ram_q;
  logic             clearing_q;
  logic [ClrAw-1:0] clr_q;
  logic             out_valid_q;
  region_e          sel_q, sel_d;

  logic [7:0] pat_mem [PatternBytes];
  logic [7:0] nt_mem  [NametableBytes];
  logic [7:0] pal_q   [PaletteBytes];
  logic [7:0] pat_rd_q, nt_rd_q, pal_rd_q;

  dec_t dec;
  logic accept;
  logic is_read, is_store;
  logic pat_we, nt_we, pal_we;
  logic [PatAw-1:0] pat_addr;
  logic [NtAw-1:0]  nt_addr;
  logic [7:0]       pat_wd, nt_wd;

  ppu_bmm_addr_dec u_dec (
    .bus_address_i (bus_address_i),
    .mirror_mode_i (mirror_mode_q),
    .dec_o         (dec)
  );

  assign in_ready_o  = !clearing_q && (!out_valid_q || out_ready_i);
  assign accept      = in_valid_i && in_ready_o;
  assign out_valid_o = out_valid_q;

  assign is_read  = (cmd_e'(cmd_i) == CmdRead);
  assign is_store = (cmd_e'(cmd_i) == CmdWrite) || (cmd_e'(cmd_i) == CmdLoad);

  always_comb begin
    pat_we = accept && is_store && (dec.region == RegPattern) &&
             ((cmd_e'(cmd_i) == CmdLoad) || pattern_is_ram_q);
    nt_we  = accept && is_store && (dec.region == RegNametable);
    pal_we = accept && is_store && (dec.region == RegPalette);
    sel_d  = is_read ? dec.region : RegZero;
    if (clearing_q) begin
      pat_addr = clr_q[PatAw-1:0];
      nt_addr  = clr_q[NtAw-1:0];
      pat_wd   = 8'h00;
      nt_wd    = 8'h00;
    end else begin
      pat_addr = dec.pat_idx;
      nt_addr  = dec.nt_idx;
      pat_wd   = write_data_i;
      nt_wd    = write_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mirror_mode_q    <= MirHoriz;
      pattern_is_ram_q <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CfgMirrorMode:   mirror_mode_q    <= cfg_data_i;
        CfgPatternIsRam: pattern_is_ram_q <= cfg_data_i[0];
        default:         mirror_mode_q    <= mirror_mode_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clearing_q <= 1'b1;
      clr_q      <= '0;
    end else if (clearing_q) begin
      clr_q <= clr_q + ClrAw'(1);
      if (clr_q == ClrAw'(ClrLen - 1)) begin
        clearing_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      sel_q       <= RegZero;
    end else begin
      if (accept) begin
        out_valid_q <= 1'b1;
        sel_q       <= sel_d;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // read data registers load only on accept so a stalled result holds
  always_ff @(posedge clk_i) begin
    if (clearing_q || pat_we) begin
      pat_mem[pat_addr] <= pat_wd;
    end
    if (accept) begin
      pat_rd_q <= pat_mem[pat_addr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (clearing_q || nt_we) begin
      nt_mem[nt_addr] <= nt_wd;
    end
    if (accept) begin
      nt_rd_q <= nt_mem[nt_addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < PaletteBytes; i++) begin
        pal_q[i] <= 8'h00;
      end
    end else if (pal_we) begin
      pal_q[dec.pal_idx] <= write_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      pal_rd_q <= pal_q[dec.pal_idx];
    end
  end

  always_comb begin
    unique case (sel_q)
      RegPattern:   read_data_o = pat_rd_q;
      RegNametable: read_data_o = nt_rd_q;
      RegPalette:   read_data_o = pal_rd_q;
      RegZero:      read_data_o = 8'h00;
      default:      read_data_o = 8'h00;
    endcase
  end

endmodule

// ===== verif/ppu_bus_memory_map_unit_test.sv =====
// self-checking testbench for the picture bus memory map unit
`timescale 1ns / 1ps
module ppu_bus_memory_map_unit_test;
  import ppu_bmm_pkg::*;

  localparam int unsigned WatchdogLimit = 50000;
  localparam int unsigned NumPhases     = 8;
  localparam int unsigned PhaseItems    = 150;

  typedef struct {
    cmd_e        cmd;
    logic [15:0] addr;
    logic [7:0]  data;
    bit          typed;
    logic [7:0]  want;
  } dir_row_t;

  typedef struct {
    bit         typed;
    logic [7:0] want;
  } pin_t;

  logic        clk_i         = 1'b0;
  logic        rst_ni        = 1'b0;
  logic        cfg_we_i      = 1'b0;
  logic        cfg_idx_i     = CfgMirrorMode;
  logic [1:0]  cfg_data_i    = 2'd0;
  logic        in_valid_i    = 1'b0;
  logic        in_ready_o;
  logic [1:0]  cmd_i         = CmdRead;
  logic [15:0] bus_address_i = 16'h0000;
  logic [7:0]  write_data_i  = 8'h00;
  logic        out_valid_o;
  logic        out_ready_i   = 1'b0;
  logic [7:0]  read_data_o;

  // predictor state
  logic [7:0] pat_mem [PatternBytes];
  logic [7:0] nt_mem  [NametableBytes];
  logic [7:0] pal_mem [PaletteBytes];
  mirror_e    mirror_m;
  logic       pat_ram_m;

  logic [7:0]  read_bytes_q [$];
  pin_t        pinned_q [$];
  dir_row_t    dir_rows [$];
  logic [15:0] hot_addr [16];

  int unsigned n_sent;
  int unsigned n_checked;
  int unsigned n_errs;
  int unsigned idle_cycles;
  int unsigned ready_style;

  ppu_bus_memory_map_unit i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .cmd_i         (cmd_i),
    .bus_address_i (bus_address_i),
    .write_data_i  (write_data_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .read_data_o   (read_data_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // one bus access against the predictor copy of the stores
  function automatic logic [7:0] map_access(cmd_e c, logic [15:0] addr, logic [7:0] d);
    logic [15:0] a;
    logic [7:0]  rd;
    logic        tbl;
    int unsigned nt_i;
    int unsigned pal_i;
    int unsigned pat_i;
    a  = addr;
    rd = 8'h00;
    if (a >= 16'h4000) a = {4'h3, a[11:0]};
    case (mirror_m)
      MirSingleLo: tbl = 1'b0;
      MirSingleHi: tbl = 1'b1;
      MirVert:     tbl = a[10];
      default:     tbl = a[11];
    endcase
    nt_i  = ((tbl ? 1024 : 0) + a[9:0]) % NametableBytes;
    // sprite backdrop entries alias the background ones
    pal_i = ((a[1:0] != 2'b00) ? a[4:0] : {1'b0, a[3:0]}) % PaletteBytes;
    pat_i = a[12:0] % PatternBytes;
    if (c == CmdRead) begin
      if (a < 16'h2000)       rd = pat_mem[pat_i];
      else if (a >= 16'h3F00) rd = pal_mem[pal_i];
      else                    rd = nt_mem[nt_i];
    end else if (c == CmdWrite || c == CmdLoad) begin
      if (a < 16'h2000) begin
        if (c == CmdLoad || pat_ram_m) pat_mem[pat_i] = d;
      end else if (a >= 16'h3F00) begin
        pal_mem[pal_i] = d;
      end else begin
        nt_mem[nt_i] = d;
      end
    end
    return rd;
  endfunction

  function automatic logic [15:0] pick_address();
    logic [15:0] a;
    case ($urandom_range(9))
      0, 1, 2: a = 16'($urandom_range(16'h1FFF));
      3, 4, 5: a = 16'($urandom_range(16'h3EFF, 16'h2000));
      6, 7:    a = 16'($urandom_range(16'h3FFF, 16'h3F00));
      8:       a = 16'($urandom_range(16'hFFFF, 16'h4000));
      default: begin
        // revisit a written location, often through a mirror alias
        a = hot_addr[$urandom_range(15)];
        if ($urandom_range(1) == 1) a = a ^ (16'($urandom_range(3)) << 10);
        if (a >= 16'h2000 && $urandom_range(2) == 0) a[15:14] = 2'($urandom_range(3));
      end
    endcase
    return a;
  endfunction

  function automatic cmd_e pick_cmd();
    int unsigned r;
    r = $urandom_range(15);
    if (r <= 6)       return CmdRead;
    else if (r <= 11) return CmdWrite;
    else if (r <= 14) return CmdLoad;
    else              return CmdNone;
  endfunction

  task automatic send_access(cmd_e c, logic [15:0] a, logic [7:0] d, bit typed,
                             logic [7:0] want);
    pinned_q.push_back('{typed, want});
    in_valid_i    <= 1'b1;
    cmd_i         <= c;
    bus_address_i <= a;
    write_data_i  <= d;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    n_sent++;
  endtask

  // wait until the result of every accepted access has come back
  task automatic drain();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (read_bytes_q.size() != 0);
  endtask

  // leaves the write enable high, the caller drops it after the last write
  task automatic write_reg(logic idx, logic [1:0] val);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    if (idx == CfgMirrorMode) mirror_m = mirror_e'(val);
    else                      pat_ram_m = val[0];
    @(posedge clk_i);
  endtask

  // receiver: drives out_ready_i in one of four stall styles, redrawn at random
  always @(posedge clk_i) begin : sink_pacing
    int unsigned stall_left;
    int unsigned tick;
    tick++;
    if (tick % 128 == 0) ready_style = $urandom_range(3);
    if (stall_left != 0) begin
      out_ready_i <= 1'b0;
      stall_left--;
    end else begin
      case (ready_style)
        0: out_ready_i <= 1'b1;
        1: out_ready_i <= ($urandom_range(3) != 0);
        2: out_ready_i <= (tick % 3 != 0);
        default: begin
          if ($urandom_range(7) == 0) begin
            out_ready_i <= 1'b0;
            stall_left = $urandom_range(8, 1);
          end else begin
            out_ready_i <= 1'b1;
          end
        end
      endcase
    end
  end

  always @(posedge clk_i) begin : scoreboard
    pin_t       pin;
    logic [7:0] want;
    logic [7:0] pred;
    bit         moved;
    moved = 1'b0;
    if (out_valid_o && out_ready_i) begin
      moved = 1'b1;
      if (read_bytes_q.size() == 0) begin
        $display("%0t: result with no request pending, read_data %02h", $time, read_data_o);
        n_errs++;
      end else begin
        want = read_bytes_q.pop_front();
        n_checked++;
        if (read_data_o !== want) begin
          $display("%0t: read_data mismatch, expected %02h, actual %02h",
                   $time, want, read_data_o);
          n_errs++;
        end
      end
    end
    if (in_valid_i && in_ready_o) begin
      moved = 1'b1;
      pin   = pinned_q.pop_front();
      pred  = map_access(cmd_e'(cmd_i), bus_address_i, write_data_i);
      read_bytes_q.push_back(pin.typed ? pin.want : pred);
    end
    idle_cycles = moved ? 0 : idle_cycles + 1;
    if (idle_cycles >= WatchdogLimit) begin
      $display("%0t: no request moved for %0d cycles", $time, WatchdogLimit);
      $display("ppu_bus_memory_map_unit_test: errors");
      $finish;
    end
  end

  initial begin : stimulus
    int unsigned burst_left;
    int unsigned gap;
    cmd_e        c;
    logic [15:0] a;
    logic [7:0]  d;
    bit          steady;

    foreach (pat_mem[i]) pat_mem[i] = 8'h00;
    foreach (nt_mem[i])  nt_mem[i]  = 8'h00;
    foreach (pal_mem[i]) pal_mem[i] = 8'h00;
    foreach (hot_addr[i]) hot_addr[i] = 16'($urandom_range(16'hFFFF));
    mirror_m  = MirHoriz;
    pat_ram_m = 1'b0;

    // reset state, pattern protection, mirrors and folding
    dir_rows.push_back('{CmdRead,  16'h0000, 8'h00, 1'b1, 8'h00});
    dir_rows.push_back('{CmdRead,  16'hFFFF, 8'h00, 1'b1, 8'h00});
    dir_rows.push_back('{CmdRead,  16'h2000, 8'h00, 1'b1, 8'h00});
    dir_rows.push_back('{CmdWrite, 16'h0000, 8'hFF, 1'b1, 8'h00});
    dir_rows.push_back('{CmdRead,  16'h0000, 8'h00, 1'b1, 8'h00});
    dir_rows.push_back('{CmdLoad,  16'h0000, 8'hFF, 1'b1, 8'h00});
    dir_rows.push_back('{CmdRead,  16'h0000, 8'h00, 1'b0, 8'h00});
    dir_rows.push_back('{CmdLoad,  16'h1FFF, 8'hA5, 1'b1, 8'h00});
    dir_rows.push_back('{CmdNone,  16'h1FFF, 8'h5A, 1'b1, 8'h00});
    dir_rows.push_back('{CmdRead,  16'h1FFF, 8'h00, 1'b0, 8'h00});
    dir_rows.push_back('{CmdWrite, 16'h2000, 8'h11, 1'b1, 8'h00});
    dir_rows.push_back('{CmdRead,  16'h2400, 8'h00, 1'b0, 8'h00});
    dir_rows.push_back('{CmdRead,  16'h2800, 8'h00, 1'b0, 8'h00});
    dir_rows.push_back('{CmdWrite, 16'h2C05, 8'h22, 1'b1, 8'h00});
    dir_rows.push_back('{CmdRead,  16'h3C05, 8'h00, 1'b0, 8'h00});
    dir_rows.push_back('{CmdLoad,  16'h3F10, 8'h33, 1'b1, 8'h00});
    dir_rows.push_back('{CmdRead,  16'h3F00, 8'h00, 1'b0, 8'h00});
    dir_rows.push_back('{CmdWrite, 16'h3F1F, 8'h44, 1'b1, 8'h00});
    dir_rows.push_back('{CmdRead,  16'h7F1F, 8'h00, 1'b0, 8'h00});
    dir_rows.push_back('{CmdWrite, 16'h3F04, 8'h55, 1'b1, 8'h00});
    dir_rows.push_back('{CmdRead,  16'h3F14, 8'h00, 1'b0, 8'h00});
    dir_rows.push_back('{CmdWrite, 16'h3EFF, 8'h00, 1'b1, 8'h00});
    dir_rows.push_back('{CmdRead,  16'h2EFF, 8'h00, 1'b0, 8'h00});
    dir_rows.push_back('{CmdRead,  16'h4000, 8'h00, 1'b0, 8'h00});
    dir_rows.push_back('{CmdRead,  16'hC3FF, 8'h00, 1'b0, 8'h00});

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    foreach (dir_rows[i])
      send_access(dir_rows[i].cmd, dir_rows[i].addr, dir_rows[i].data,
                  dir_rows[i].typed, dir_rows[i].want);

    // each phase pairs one mirroring mode with one pattern protection setting
    for (int unsigned p = 0; p < NumPhases; p++) begin
      drain();
      repeat (2) @(posedge clk_i);
      write_reg(CfgMirrorMode, 2'(p % 4));
      write_reg(CfgPatternIsRam, {1'b0, 1'(p / 4)});
      cfg_we_i <= 1'b0;
      steady     = (p == 2 || p == 6);
      burst_left = 0;
      for (int unsigned k = 0; k < PhaseItems; k++) begin
        if (burst_left == 0) begin
          burst_left = $urandom_range(24, 1);
          gap = steady ? 0 : $urandom_range(6);
          if (gap != 0) begin
            in_valid_i <= 1'b0;
            repeat (gap) @(posedge clk_i);
          end
        end
        burst_left--;
        if (p == 5 && k == PhaseItems / 2) drain();
        c = pick_cmd();
        a = pick_address();
        case ($urandom_range(9))
          0:       d = 8'h00;
          1:       d = 8'hFF;
          default: d = 8'($urandom_range(255));
        endcase
        if (c == CmdWrite || c == CmdLoad) hot_addr[$urandom_range(15)] = a;
        send_access(c, a, d, 1'b0, 8'h00);
      end
    end

    drain();
    repeat (4) @(posedge clk_i);
    if (read_bytes_q.size() != 0) begin
      $display("%0t: %0d read results never arrived", $time, read_bytes_q.size());
      n_errs += read_bytes_q.size();
    end
    $display("%0d accesses sent, %0d results checked, %0d mismatches", n_sent, n_checked,
             n_errs);
    $display("covered: all four mirroring modes, pattern store as rom and as ram, stalls");
    if (n_errs == 0) begin
      $display("ppu_bus_memory_map_unit_test: clean");
    end else begin
      $display("ppu_bus_memory_map_unit_test: errors");
    end
    $finish;
  end

endmodule
